/* hdl/amf_pkg.sv */
// amf_pkg: shared types and constants of the above-mean filter
// used by every module of the block and by its checker
package amf_pkg;

    localparam int DATA_W        = 32;
    localparam int DEPTH_MAX     = 64;
    localparam int DEPTH_DEFAULT = 64;
    localparam int CNT_W_MAX     = $clog2(DEPTH_MAX + 1);
    localparam int SUM_W_MAX     = DATA_W + $clog2(DEPTH_MAX);
    localparam int CMP_W         = DATA_W + CNT_W_MAX;
    localparam int STATUS_W      = 2;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NONE     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

    typedef struct packed {
        logic                        bank;
        logic signed [SUM_W_MAX-1:0] sum;
        logic [CNT_W_MAX-1:0]        count;
        logic                        overflow;
    } block_desc_t;

    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_READ,
        SCAN_MUL,
        SCAN_CMP,
        SCAN_FINISH
    } scan_state_t;

endpackage

/* hdl/above_mean_filter_unit.sv */
// above_mean_filter_unit: top level of the above-mean filter
// joins amf_front, amf_queue and amf_back; depends on amf_pkg
//
//  channel | signals                                  | transfer when
//  --------+------------------------------------------+-----------------------------
//  sample  | sample_value, last_item                  | sample_valid && sample_ready
//  result  | kept_value, status, last_result          | result_valid && result_ready
//
//  while sample_ready is high, the front loads one sample per cycle into its bank
//  scan of a block: one pass per stored entry through the memory read,
//  the registered multiply and the compare, then a closing step
//  two memory banks: the front loads the next block while the back scans one;
//  sample_ready drops only when both banks hold closed blocks
//  reset clears all control state at once; no clearing pass
//  a stalled result holds the scan at its next emit, the front keeps loading
module above_mean_filter_unit #(
    parameter int DEPTH = amf_pkg::DEPTH_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              sample_valid,
    output logic                              sample_ready,
    input  logic signed [amf_pkg::DATA_W-1:0] sample_value,
    input  logic                              last_item,
    output logic                              result_valid,
    input  logic                              result_ready,
    output logic signed [amf_pkg::DATA_W-1:0] kept_value,
    output logic [amf_pkg::STATUS_W-1:0]      status,
    output logic                              last_result
);
    import amf_pkg::*;

    logic                    queue_full;
    logic                    queue_not_empty;
    logic                    desc_push;
    logic                    desc_pop;
    block_desc_t             push_desc;
    block_desc_t             head_desc;
    logic                    wr_en;
    logic [$clog2(DEPTH):0]  wr_addr;
    logic [DATA_W-1:0]       wr_data;

    amf_front #(
        .DEPTH (DEPTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample_value (sample_value),
        .last_item    (last_item),
        .queue_full   (queue_full),
        .desc_push    (desc_push),
        .desc         (push_desc),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data)
    );

    amf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (desc_push),
        .push_desc (push_desc),
        .pop       (desc_pop),
        .full      (queue_full),
        .not_empty (queue_not_empty),
        .head      (head_desc)
    );

    amf_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .desc_ready   (queue_not_empty),
        .desc         (head_desc),
        .desc_pop     (desc_pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .kept_value   (kept_value),
        .status       (status),
        .last_result  (last_result)
    );

endmodule

/* hdl/amf_front.sv */
// amf_front: takes samples, writes them into the active bank, keeps sum and count
// closes a block on the last sample and queues its descriptor; depends on amf_pkg
module amf_front #(
    parameter int DEPTH = amf_pkg::DEPTH_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  sample_valid,
    output logic                                  sample_ready,
    input  logic signed [amf_pkg::DATA_W-1:0]     sample_value,
    input  logic                                  last_item,
    input  logic                                  queue_full,
    output logic                                  desc_push,
    output amf_pkg::block_desc_t                  desc,
    output logic                                  wr_en,
    output logic [$clog2(DEPTH):0]                wr_addr,
    output logic [amf_pkg::DATA_W-1:0]            wr_data
);
    import amf_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = DATA_W + $clog2(DEPTH);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic                    bank_reg;
    logic [CNT_W-1:0]        count_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic                    overflow_reg;

    logic                    accept;
    logic                    room;
    logic [CNT_W-1:0]        count_next;
    logic signed [SUM_W-1:0] sum_next;
    logic                    overflow_next;

    assign sample_ready = !queue_full;
    assign accept       = sample_valid && sample_ready;
    assign room         = (count_reg != CNT_FULL);

    always_comb
    begin
        count_next    = count_reg;
        sum_next      = sum_reg;
        overflow_next = overflow_reg;
        if (room)
        begin
            count_next = count_reg + CNT_W'(1);
            sum_next   = sum_reg + SUM_W'(sample_value);
        end
        else
        begin
            overflow_next = 1'b1;
        end
    end

    assign wr_en   = accept && room;
    assign wr_addr = {bank_reg, count_reg[IDX_W-1:0]};
    assign wr_data = sample_value;

    assign desc_push     = accept && last_item;
    assign desc.bank     = bank_reg;
    assign desc.sum      = SUM_W_MAX'(sum_next);
    assign desc.count    = CNT_W_MAX'(count_next);
    assign desc.overflow = overflow_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_reg     <= 1'b0;
            count_reg    <= '0;
            sum_reg      <= '0;
            overflow_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (last_item)
            begin
                bank_reg     <= !bank_reg;
                count_reg    <= '0;
                sum_reg      <= '0;
                overflow_reg <= 1'b0;
            end
            else
            begin
                count_reg    <= count_next;
                sum_reg      <= sum_next;
                overflow_reg <= overflow_next;
            end
        end
    end

endmodule

/* hdl/amf_queue.sv */
// amf_queue: two-entry queue of closed-block descriptors between front and back
// one entry per memory bank; depends on amf_pkg
module amf_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  amf_pkg::block_desc_t push_desc,
    input  logic                 pop,
    output logic                 full,
    output logic                 not_empty,
    output amf_pkg::block_desc_t head
);
    import amf_pkg::*;

    block_desc_t entry0_reg;
    block_desc_t entry1_reg;
    logic [1:0]  fill_reg;

    assign full      = (fill_reg == 2'd2);
    assign not_empty = (fill_reg != 2'd0);
    assign head      = entry0_reg;

    always_ff @(posedge clk)
    begin
        if (push && pop)
        begin
            if (fill_reg == 2'd1)
            begin
                entry0_reg <= push_desc;
            end
            else
            begin
                entry0_reg <= entry1_reg;
                entry1_reg <= push_desc;
            end
        end
        else if (push)
        begin
            if (fill_reg == 2'd0)
            begin
                entry0_reg <= push_desc;
            end
            else
            begin
                entry1_reg <= push_desc;
            end
        end
        else if (pop)
        begin
            entry0_reg <= entry1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= 2'd0;
        end
        else if (push && !pop)
        begin
            fill_reg <= fill_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            fill_reg <= fill_reg - 2'd1;
        end
    end

endmodule

/* hdl/amf_back.sv */
// amf_back: two-bank sample memory and the scan that emits values above the mean
// one stored entry per read-multiply-compare pass; depends on amf_pkg
module amf_back #(
    parameter int DEPTH = amf_pkg::DEPTH_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              wr_en,
    input  logic [$clog2(DEPTH):0]            wr_addr,
    input  logic [amf_pkg::DATA_W-1:0]        wr_data,
    input  logic                              desc_ready,
    input  amf_pkg::block_desc_t              desc,
    output logic                              desc_pop,
    output logic                              result_valid,
    input  logic                              result_ready,
    output logic signed [amf_pkg::DATA_W-1:0] kept_value,
    output logic [amf_pkg::STATUS_W-1:0]      status,
    output logic                              last_result
);
    import amf_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int ADDR_W = IDX_W + 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int MEM_D = 2 ** ADDR_W;

    logic [DATA_W-1:0] mem [MEM_D];

    scan_state_t              state_reg;
    scan_state_t              state_next;
    logic [CNT_W-1:0]         idx_reg;
    logic [DATA_W-1:0]        rdata_reg;
    logic signed [DATA_W-1:0] val_reg;
    logic signed [CMP_W-1:0]  prod_reg;
    logic signed [DATA_W-1:0] pend_reg;
    logic                     have_pend_reg;
    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] out_value_reg;
    logic [STATUS_W-1:0]      out_status_reg;
    logic                     out_last_reg;

    logic [CNT_W-1:0]         count;
    logic [ADDR_W-1:0]        rd_addr;
    logic                     rd_en;
    logic                     above;
    logic                     slot_free;
    logic                     emit;
    logic                     scan_done;
    logic [STATUS_W-1:0]      ok_status;
    logic signed [DATA_W-1:0] emit_value;
    logic [STATUS_W-1:0]      emit_status;
    logic                     emit_last;

    assign count     = desc.count[CNT_W-1:0];
    assign rd_addr   = {desc.bank, idx_reg[IDX_W-1:0]};
    assign above     = prod_reg > CMP_W'(desc.sum);
    assign slot_free = !out_valid_reg || result_ready;
    assign scan_done = (idx_reg == count);
    assign ok_status = desc.overflow ? ST_OVERFLOW : ST_OK;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            SCAN_IDLE:
            begin
                if (desc_ready)
                begin
                    state_next = SCAN_READ;
                end
            end
            SCAN_READ:
            begin
                state_next = scan_done ? SCAN_FINISH : SCAN_MUL;
            end
            SCAN_MUL:
            begin
                state_next = SCAN_CMP;
            end
            SCAN_CMP:
            begin
                if (!(above && have_pend_reg && !slot_free))
                begin
                    state_next = SCAN_READ;
                end
            end
            SCAN_FINISH:
            begin
                if (slot_free)
                begin
                    state_next = SCAN_IDLE;
                end
            end
            default:
            begin
                state_next = SCAN_IDLE;
            end
        endcase
    end

    // outputs of the state machine
    always_comb
    begin
        rd_en       = 1'b0;
        emit        = 1'b0;
        desc_pop    = 1'b0;
        emit_value  = pend_reg;
        emit_status = ok_status;
        emit_last   = 1'b0;
        unique case (state_reg)
            SCAN_READ:
            begin
                rd_en = !scan_done;
            end
            SCAN_CMP:
            begin
                emit = above && have_pend_reg && slot_free;
            end
            SCAN_FINISH:
            begin
                emit      = slot_free;
                desc_pop  = slot_free;
                emit_last = 1'b1;
                if (!have_pend_reg)
                begin
                    emit_value  = '0;
                    emit_status = desc.overflow ? ST_OVERFLOW : ST_NONE;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == SCAN_MUL)
        begin
            val_reg  <= $signed(rdata_reg);
            prod_reg <= CMP_W'($signed(rdata_reg)) * CMP_W'($signed({1'b0, count}));
        end
        if (state_reg == SCAN_CMP && state_next == SCAN_READ && above)
        begin
            pend_reg <= val_reg;
        end
        if (emit)
        begin
            out_value_reg  <= emit_value;
            out_status_reg <= emit_status;
            out_last_reg   <= emit_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= SCAN_IDLE;
            idx_reg       <= '0;
            have_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == SCAN_IDLE)
            begin
                idx_reg       <= '0;
                have_pend_reg <= 1'b0;
            end
            else if (state_reg == SCAN_CMP && state_next == SCAN_READ)
            begin
                idx_reg <= idx_reg + CNT_W'(1);
                if (above)
                begin
                    have_pend_reg <= 1'b1;
                end
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign result_valid = out_valid_reg;
    assign kept_value   = out_value_reg;
    assign status       = out_status_reg;
    assign last_result  = out_last_reg;

endmodule

/* hdl/amf_checker.sv */
// amf_checker: port-level assertions for above_mean_filter_unit
// bound to the top level below; depends on amf_pkg
module amf_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              sample_valid,
    input logic                              sample_ready,
    input logic signed [amf_pkg::DATA_W-1:0] sample_value,
    input logic                              last_item,
    input logic                              result_valid,
    input logic                              result_ready,
    input logic signed [amf_pkg::DATA_W-1:0] kept_value,
    input logic [amf_pkg::STATUS_W-1:0]      status,
    input logic                              last_result
);
    import amf_pkg::*;

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(kept_value) && $stable(status) && $stable(last_result))
    else $error("stalled result changed");

    // an empty answer is a single closing zero
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status == ST_NONE |-> last_result && kept_value == '0)
    else $error("none-above result malformed");

    // no reserved status code
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> status == ST_OK || status == ST_NONE || status == ST_OVERFLOW)
    else $error("reserved status code");

    // nothing on the result side right out of reset
    assert property (@(posedge clk)
        $rose(rst_n) |-> !result_valid)
    else $error("result valid right after reset");

endmodule

bind above_mean_filter_unit amf_checker u_amf_checker (.*);
